FILE: rtl/tdcm_pkg.sv
// Shared constants, types and the cosine gain table of the two-deck crossfade mixer.
package tdcm_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int POSITION_BITS = 12;
    localparam int COS_ENTRIES   = 256;

    localparam int POS_W      = POSITION_BITS + 1;
    localparam int FULL_POS   = 1 << POSITION_BITS;
    localparam int GAIN_FRAC  = 15;
    localparam int GAIN_BITS  = GAIN_FRAC + 1;
    localparam int UNITY_GAIN = 1 << GAIN_FRAC;
    localparam int COS_IDX_W  = $clog2(COS_ENTRIES + 1);
    localparam int SUM_W      = SAMPLE_BITS + 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = POS_W;

    localparam logic [CFG_IDX_W-1:0] REG_POSITION   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_MODE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_AIR_A      = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_AIR_B      = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_CUE_A      = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_CUE_B      = CFG_IDX_W'(5);

    // Curve modes; the unused code falls back to linear.
    localparam logic [1:0] MODE_LINEAR = 2'd0;
    localparam logic [1:0] MODE_COSINE = 2'd1;
    localparam logic [1:0] MODE_SQUARE = 2'd2;

    typedef struct packed {
        logic load_in;
        logic load_prod;
    } t_lane_ctrl;

    typedef struct packed {
        logic air_a;
        logic air_b;
        logic cue_a;
        logic cue_b;
    } t_route;

    typedef logic [COS_ENTRIES:0][GAIN_BITS-1:0] t_cos_tab;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [8] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240
    };

    // Quarter-wave cosine in Q15, from an eight-term series in Q30 with truncating steps.
    function automatic t_cos_tab build_cos_tab();
        t_cos_tab    tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] mag;
        logic [63:0] g;
        longint      sum;
        tab = '0;
        for (int i = 0; i <= COS_ENTRIES; i++) begin
            x   = (HALF_PI_Q30 * 64'(i)) / COS_ENTRIES;
            x2  = (x * x) >> 30;
            mag = 64'd1 << 30;
            sum = longint'(mag);
            for (int k = 1; k <= 8; k++) begin
                mag = ((mag * x2) >> 30) / TAYLOR_DIV[k-1];
                if ((k % 2) == 1) begin
                    sum = sum - longint'(mag);
                end else begin
                    sum = sum + longint'(mag);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            g = (64'(sum) + (64'd1 << 14)) >> 15;
            if (g > 64'(UNITY_GAIN)) begin
                g = 64'(UNITY_GAIN);
            end
            tab[i] = GAIN_BITS'(g);
        end
        return tab;
    endfunction

    localparam t_cos_tab COS_TAB = build_cos_tab();

endpackage

FILE: rtl/tdcm_lane.sv
// One deck lane: gain from the fader position, sample capture and gain scaling.
module tdcm_lane (
    input  logic                                    i_clk,
    input  tdcm_pkg::t_lane_ctrl                    i_ctrl,
    input  logic [tdcm_pkg::POS_W-1:0]              i_lin_pos,
    input  logic [tdcm_pkg::POS_W-1:0]              i_cos_pos,
    input  logic [1:0]                              i_mode,
    input  logic signed [tdcm_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic signed [tdcm_pkg::SAMPLE_BITS-1:0] o_scaled
);

    localparam int LIN_W  = tdcm_pkg::POS_W + tdcm_pkg::GAIN_FRAC;
    localparam int SQ_W   = 2 * tdcm_pkg::POS_W + tdcm_pkg::GAIN_FRAC;
    localparam int IDX_W  = tdcm_pkg::POS_W + tdcm_pkg::COS_IDX_W;
    localparam int PROD_W = tdcm_pkg::SAMPLE_BITS + tdcm_pkg::GAIN_BITS + 1;

    logic [LIN_W-1:0]                      lin_wide;
    logic [2*tdcm_pkg::POS_W-1:0]          pos_sq;
    logic [SQ_W-1:0]                       sq_wide;
    logic [IDX_W-1:0]                      idx_wide;
    logic [IDX_W-1:0]                      idx_shift;
    logic [tdcm_pkg::COS_IDX_W-1:0]        cos_idx;
    logic [tdcm_pkg::GAIN_BITS-1:0]        n_gain;
    logic [tdcm_pkg::GAIN_BITS-1:0]        r_gain;
    logic signed [tdcm_pkg::SAMPLE_BITS-1:0] r_sample;
    logic signed [PROD_W-1:0]              n_prod;
    logic signed [PROD_W-1:0]              r_prod;
    logic signed [PROD_W-1:0]              rounded;

    always_comb begin
        lin_wide = {i_lin_pos, {tdcm_pkg::GAIN_FRAC{1'b0}}}
                 + LIN_W'(tdcm_pkg::FULL_POS / 2);
        pos_sq   = (2 * tdcm_pkg::POS_W)'(i_lin_pos) * (2 * tdcm_pkg::POS_W)'(i_lin_pos);
        sq_wide  = {pos_sq, {tdcm_pkg::GAIN_FRAC{1'b0}}}
                 + (SQ_W'(1) << (2 * tdcm_pkg::POSITION_BITS - 1));
        idx_wide = IDX_W'(i_cos_pos) * IDX_W'(tdcm_pkg::COS_ENTRIES)
                 + IDX_W'(tdcm_pkg::FULL_POS / 2);
        idx_shift = idx_wide >> tdcm_pkg::POSITION_BITS;
        if (idx_shift > IDX_W'(tdcm_pkg::COS_ENTRIES)) begin
            cos_idx = tdcm_pkg::COS_IDX_W'(tdcm_pkg::COS_ENTRIES);
        end else begin
            cos_idx = idx_shift[tdcm_pkg::COS_IDX_W-1:0];
        end
        case (i_mode)
            tdcm_pkg::MODE_COSINE: n_gain = tdcm_pkg::COS_TAB[cos_idx];
            tdcm_pkg::MODE_SQUARE:
                n_gain = tdcm_pkg::GAIN_BITS'(sq_wide >> (2 * tdcm_pkg::POSITION_BITS));
            default: n_gain = tdcm_pkg::GAIN_BITS'(lin_wide >> tdcm_pkg::POSITION_BITS);
        endcase
    end

    // The gain follows the registers in the next cycle, ahead of the multiply stage.
    always_ff @(posedge i_clk) begin
        r_gain <= n_gain;
    end

    assign n_prod = PROD_W'(r_sample) * $signed({1'b0, r_gain});

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_in) begin
            r_sample <= i_sample;
        end
        if (i_ctrl.load_prod) begin
            r_prod <= n_prod;
        end
    end

    // Round half up, then drop the gain fraction; the result always fits a sample.
    assign rounded  = r_prod + (PROD_W'(1) <<< (tdcm_pkg::GAIN_FRAC - 1));
    assign o_scaled = tdcm_pkg::SAMPLE_BITS'(rounded >>> tdcm_pkg::GAIN_FRAC);

endmodule

FILE: rtl/tdcm_merge.sv
// Routing of the scaled decks onto the master and cue buses, with master saturation.
module tdcm_merge (
    input  logic                                    i_clk,
    input  logic                                    i_load,
    input  tdcm_pkg::t_route                        i_route,
    input  logic signed [tdcm_pkg::SAMPLE_BITS-1:0] i_scaled_a,
    input  logic signed [tdcm_pkg::SAMPLE_BITS-1:0] i_scaled_b,
    output logic signed [tdcm_pkg::SAMPLE_BITS-1:0] o_master_sample,
    output logic signed [tdcm_pkg::SUM_W-1:0]       o_cue_sample,
    output logic                                    o_cue_active
);

    localparam logic signed [tdcm_pkg::SUM_W-1:0] SUM_MAX =
        tdcm_pkg::SUM_W'((64'sd1 <<< (tdcm_pkg::SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [tdcm_pkg::SUM_W-1:0] SUM_MIN = tdcm_pkg::SUM_W'(-SUM_MAX - 1);

    logic signed [tdcm_pkg::SUM_W-1:0]       ext_a;
    logic signed [tdcm_pkg::SUM_W-1:0]       ext_b;
    logic signed [tdcm_pkg::SUM_W-1:0]       master_sum;
    logic signed [tdcm_pkg::SUM_W-1:0]       n_cue;
    logic signed [tdcm_pkg::SAMPLE_BITS-1:0] n_master;
    logic signed [tdcm_pkg::SAMPLE_BITS-1:0] r_master;
    logic signed [tdcm_pkg::SUM_W-1:0]       r_cue;
    logic                                    r_cue_active;

    always_comb begin
        ext_a      = tdcm_pkg::SUM_W'(i_scaled_a);
        ext_b      = tdcm_pkg::SUM_W'(i_scaled_b);
        master_sum = (i_route.air_a ? ext_a : '0) + (i_route.air_b ? ext_b : '0);
        n_cue      = (i_route.cue_a ? ext_a : '0) + (i_route.cue_b ? ext_b : '0);
        if (master_sum > SUM_MAX) begin
            n_master = tdcm_pkg::SAMPLE_BITS'(SUM_MAX);
        end else if (master_sum < SUM_MIN) begin
            n_master = tdcm_pkg::SAMPLE_BITS'(SUM_MIN);
        end else begin
            n_master = master_sum[tdcm_pkg::SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_master     <= n_master;
            r_cue        <= n_cue;
            r_cue_active <= i_route.cue_a | i_route.cue_b;
        end
    end

    assign o_master_sample = r_master;
    assign o_cue_sample    = r_cue;
    assign o_cue_active    = r_cue_active;

endmodule

FILE: rtl/two_deck_crossfade_mixer.sv
// Top level of the two-deck crossfade mixer: registers, lane pipeline and flow control.
//
//  channel   direction  handshake           payload
//  input     in         i_valid / o_stall   i_sample_a, i_sample_b
//  output    out        o_valid / i_stall   o_master_sample, o_cue_sample, o_cue_active
//  config    in         i_cfg_we            i_cfg_index, i_cfg_data
//
// One request is accepted per clock while o_stall is low; each result passes through sample
// capture, lane multiply and the merge register on its way to the output.
// Reset is synchronous and active low; it empties the pipeline and restores the registers.
// A stall on the output holds the full stages, lets empty ones fill, and backs up to o_stall only once all are full.
module two_deck_crossfade_mixer (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic signed [tdcm_pkg::SAMPLE_BITS-1:0] i_sample_a,
    input  logic signed [tdcm_pkg::SAMPLE_BITS-1:0] i_sample_b,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [tdcm_pkg::SAMPLE_BITS-1:0] o_master_sample,
    output logic signed [tdcm_pkg::SUM_W-1:0]       o_cue_sample,
    output logic                                    o_cue_active,
    input  logic                                    i_cfg_we,
    input  logic [tdcm_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [tdcm_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    logic [tdcm_pkg::POS_W-1:0] r_position;
    logic [1:0]                 r_curve_mode;
    tdcm_pkg::t_route           r_route;

    logic [tdcm_pkg::POS_W-1:0] pos_p;
    logic [tdcm_pkg::POS_W-1:0] pos_q;

    logic r_v0, r_v1, r_v2;
    logic en0, en1, en2;
    tdcm_pkg::t_lane_ctrl lane_ctrl;

    logic signed [tdcm_pkg::SAMPLE_BITS-1:0] scaled_a;
    logic signed [tdcm_pkg::SAMPLE_BITS-1:0] scaled_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position    <= tdcm_pkg::POS_W'(tdcm_pkg::FULL_POS / 2);
            r_curve_mode  <= tdcm_pkg::MODE_LINEAR;
            r_route.air_a <= 1'b1;
            r_route.air_b <= 1'b1;
            r_route.cue_a <= 1'b0;
            r_route.cue_b <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tdcm_pkg::REG_POSITION:   r_position    <= i_cfg_data;
                tdcm_pkg::REG_CURVE_MODE: r_curve_mode  <= i_cfg_data[1:0];
                tdcm_pkg::REG_AIR_A:      r_route.air_a <= i_cfg_data[0];
                tdcm_pkg::REG_AIR_B:      r_route.air_b <= i_cfg_data[0];
                tdcm_pkg::REG_CUE_A:      r_route.cue_a <= i_cfg_data[0];
                tdcm_pkg::REG_CUE_B:      r_route.cue_b <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Positions past full deck B saturate, so neither gain goes negative.
    assign pos_p = (r_position > tdcm_pkg::POS_W'(tdcm_pkg::FULL_POS))
                 ? tdcm_pkg::POS_W'(tdcm_pkg::FULL_POS) : r_position;
    assign pos_q = tdcm_pkg::POS_W'(tdcm_pkg::FULL_POS) - pos_p;

    assign en2 = !r_v2 || !i_stall;
    assign en1 = !r_v1 || en2;
    assign en0 = !r_v0 || en1;

    assign o_stall = !en0;
    assign o_valid = r_v2;

    assign lane_ctrl.load_in   = en0;
    assign lane_ctrl.load_prod = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en0) begin
                r_v0 <= i_valid;
            end
            if (en1) begin
                r_v1 <= r_v0;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // Deck A takes its linear and squared gain from the distance to full B,
    // and its cosine gain from the position itself; deck B the other way round.
    tdcm_lane u_lane_a (
        .i_clk     (i_clk),
        .i_ctrl    (lane_ctrl),
        .i_lin_pos (pos_q),
        .i_cos_pos (pos_p),
        .i_mode    (r_curve_mode),
        .i_sample  (i_sample_a),
        .o_scaled  (scaled_a)
    );

    tdcm_lane u_lane_b (
        .i_clk     (i_clk),
        .i_ctrl    (lane_ctrl),
        .i_lin_pos (pos_p),
        .i_cos_pos (pos_q),
        .i_mode    (r_curve_mode),
        .i_sample  (i_sample_b),
        .o_scaled  (scaled_b)
    );

    tdcm_merge u_merge (
        .i_clk           (i_clk),
        .i_load          (en2),
        .i_route         (r_route),
        .i_scaled_a      (scaled_a),
        .i_scaled_b      (scaled_b),
        .o_master_sample (o_master_sample),
        .o_cue_sample    (o_cue_sample),
        .o_cue_active    (o_cue_active)
    );

    // Back-pressure reaches the input only when the output is full and held.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while the output stage could drain");

    // A request that meets no stall comes out after sample capture, lane multiply and the merge register.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_stall) ##1 !i_stall ##1 !i_stall |=> o_valid)
        else $error("result missing three cycles after an unstalled request");

    // With no deck on air the master bus is silent.
    a_master_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_route.air_a && !r_route.air_b) |-> (o_master_sample == '0))
        else $error("master output not silent with both air routes off");

endmodule

FILE: tb/two_deck_crossfade_mixer_checker.sv
// Checker for the two-deck crossfade mixer: watches both channels and the register port.
module two_deck_crossfade_mixer_checker
    import tdcm_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic                          i_req_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_a,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_b,
    input  logic                          i_res_valid,
    input  logic                          i_res_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_master_sample,
    input  logic signed [SUM_W-1:0]       i_cue_sample,
    input  logic                          i_cue_active,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_checked
);

    localparam longint MASTER_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint MASTER_LO = -(longint'(1) <<< (SAMPLE_BITS - 1));

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] master;
        logic [SUM_W-1:0]       cue;
        logic                   active;
    } t_mix_result;

    // Local copy of the register file.
    logic [POS_W-1:0] fader_pos;
    logic [1:0]       curve;
    logic             air_a;
    logic             air_b;
    logic             cue_a;
    logic             cue_b;

    logic [GAIN_BITS-1:0] cos_gain_tab [COS_ENTRIES+1];
    t_mix_result          pending_mix [$];

    // Quarter-wave cosine gains in Q15: an eight-term series in Q30 with truncating steps.
    initial begin : build_cosine_gains
        longint unsigned x;
        longint unsigned x2;
        longint unsigned mag;
        longint unsigned g;
        longint          acc;
        for (int i = 0; i <= COS_ENTRIES; i++) begin
            x   = (64'd1686629713 * longint'(i)) / COS_ENTRIES;
            x2  = (x * x) >> 30;
            mag = 64'd1 << 30;
            acc = longint'(mag);
            for (int k = 1; k <= 8; k++) begin
                mag = ((mag * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
                if (k % 2 == 1) begin
                    acc = acc - longint'(mag);
                end else begin
                    acc = acc + longint'(mag);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            g = (longint'(acc) + (64'd1 << 14)) >> 15;
            if (g > UNITY_GAIN) begin
                g = 64'(UNITY_GAIN);
            end
            cos_gain_tab[i] = GAIN_BITS'(g);
        end
    end

    function automatic longint unsigned cosine_gain(input longint unsigned pos);
        longint unsigned idx;
        idx = (pos * COS_ENTRIES + FULL_POS / 2) >> POSITION_BITS;
        if (idx > COS_ENTRIES) begin
            idx = 64'(COS_ENTRIES);
        end
        return 64'(cos_gain_tab[idx]);
    endfunction

    // Multiply by a Q15 gain and round half up; the arithmetic shift gives the floor.
    function automatic longint scale_deck(input longint s, input longint unsigned g);
        longint prod;
        prod = s * longint'(g);
        return (prod + 16384) >>> 15;
    endfunction

    function automatic t_mix_result predict_mix(input logic signed [SAMPLE_BITS-1:0] a,
                                                input logic signed [SAMPLE_BITS-1:0] b);
        longint unsigned p;
        longint unsigned q;
        longint unsigned ga;
        longint unsigned gb;
        longint          ta;
        longint          tb;
        longint          mst;
        longint          cue;
        t_mix_result     r;
        p = 64'(fader_pos);
        if (p > FULL_POS) begin
            p = 64'(FULL_POS);
        end
        q = FULL_POS - p;
        case (curve)
            MODE_COSINE: begin
                ga = cosine_gain(p);
                gb = cosine_gain(q);
            end
            MODE_SQUARE: begin
                ga = (q * q * UNITY_GAIN + (64'd1 << (2 * POSITION_BITS - 1)))
                     >> (2 * POSITION_BITS);
                gb = (p * p * UNITY_GAIN + (64'd1 << (2 * POSITION_BITS - 1)))
                     >> (2 * POSITION_BITS);
            end
            default: begin
                ga = (q * UNITY_GAIN + FULL_POS / 2) >> POSITION_BITS;
                gb = (p * UNITY_GAIN + FULL_POS / 2) >> POSITION_BITS;
            end
        endcase
        ta  = scale_deck(longint'(a), ga);
        tb  = scale_deck(longint'(b), gb);
        mst = 0;
        cue = 0;
        if (air_a) mst = mst + ta;
        if (air_b) mst = mst + tb;
        if (cue_a) cue = cue + ta;
        if (cue_b) cue = cue + tb;
        if (mst > MASTER_HI) mst = MASTER_HI;
        if (mst < MASTER_LO) mst = MASTER_LO;
        r.master = SAMPLE_BITS'(mst);
        r.cue    = SUM_W'(cue);
        r.active = cue_a | cue_b;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_mix_result want;
        if (!i_rst_n) begin
            fader_pos    = POS_W'(FULL_POS / 2);
            curve        = MODE_LINEAR;
            air_a        = 1'b1;
            air_b        = 1'b1;
            cue_a        = 1'b0;
            cue_b        = 1'b0;
            o_fail_count = 0;
            o_checked    = 0;
            pending_mix.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (pending_mix.size() == 0) begin
                    $error("result with no request outstanding: master_sample %0d",
                           i_master_sample);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want      = pending_mix.pop_front();
                    o_checked = o_checked + 1;
                    if (i_master_sample !== want.master) begin
                        $error("master_sample: expected %0d, got %0d",
                               $signed(want.master), i_master_sample);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_cue_sample !== want.cue) begin
                        $error("cue_sample: expected %0d, got %0d",
                               $signed(want.cue), i_cue_sample);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_cue_active !== want.active) begin
                        $error("cue_active: expected %0d, got %0d",
                               want.active, i_cue_active);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            // A request takes the settings in force before any write at the same edge.
            if (i_req_valid && !i_req_stall) begin
                pending_mix.push_back(predict_mix(i_sample_a, i_sample_b));
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_POSITION:   fader_pos = i_cfg_data[POS_W-1:0];
                    REG_CURVE_MODE: curve     = i_cfg_data[1:0];
                    REG_AIR_A:      air_a     = i_cfg_data[0];
                    REG_AIR_B:      air_b     = i_cfg_data[0];
                    REG_CUE_A:      cue_a     = i_cfg_data[0];
                    REG_CUE_B:      cue_b     = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        o_pending = pending_mix.size();
    end

endmodule

FILE: tb/two_deck_crossfade_mixer_tb.sv
// Testbench top for the two-deck crossfade mixer: stimulus, register settings and verdict.
module two_deck_crossfade_mixer_tb;
    import tdcm_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_REQUESTS = 900;
    localparam int HOLD_CYCLES    = 60;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(7);
    localparam logic [1:0]           MODE_SPARE   = 2'd3;
    localparam logic [POS_W-1:0]     POS_TOP      = {POS_W{1'b1}};

    typedef enum int {PACE_STEADY, PACE_RANDOM, PACE_BURSTY} t_pace;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_valid     = 1'b0;
    logic                          o_stall;
    logic signed [SAMPLE_BITS-1:0] i_sample_a  = '0;
    logic signed [SAMPLE_BITS-1:0] i_sample_b  = '0;
    logic                          o_valid;
    logic                          i_stall     = 1'b0;
    logic signed [SAMPLE_BITS-1:0] o_master_sample;
    logic signed [SUM_W-1:0]       o_cue_sample;
    logic                          o_cue_active;
    logic                          i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]          i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data  = '0;

    int    mix_failures;
    int    mix_pending;
    int    mix_checked;
    int    cycle_count   = 0;
    int    requests_sent = 0;
    int    settings_used = 0;
    int    rx_hold_len   = 0;
    t_pace tx_pace       = PACE_RANDOM;
    t_pace rx_pace       = PACE_RANDOM;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    two_deck_crossfade_mixer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_sample_a      (i_sample_a),
        .i_sample_b      (i_sample_b),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_master_sample (o_master_sample),
        .o_cue_sample    (o_cue_sample),
        .o_cue_active    (o_cue_active),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    two_deck_crossfade_mixer_checker mix_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_valid),
        .i_req_stall     (o_stall),
        .i_sample_a      (i_sample_a),
        .i_sample_b      (i_sample_b),
        .i_res_valid     (o_valid),
        .i_res_stall     (i_stall),
        .i_master_sample (o_master_sample),
        .i_cue_sample    (o_cue_sample),
        .i_cue_active    (o_cue_active),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (mix_failures),
        .o_pending       (mix_pending),
        .o_checked       (mix_checked)
    );

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, mix_pending);
            $display("two_deck_crossfade_mixer_tb: FAIL");
            $finish;
        end
    end

    function automatic int pick_wait(input t_pace pace);
        case (pace)
            PACE_STEADY: return 0;
            PACE_RANDOM: return $urandom_range(0, 18);
            default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
        endcase
    endfunction

    // Full-scale values turn up often so that the saturation paths stay busy.
    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return '0;
            3:       return $urandom_range(0, 1) ? 16'sh0001 : 16'shffff;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic drive_request(input logic signed [SAMPLE_BITS-1:0] a,
                                 input logic signed [SAMPLE_BITS-1:0] b);
        int gap;
        gap = pick_wait(tx_pace);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid    = 1'b1;
        i_sample_a = a;
        i_sample_b = b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        requests_sent = requests_sent + 1;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic settle_quiet();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (mix_pending != 0) @(negedge i_clk);
    endtask

    // Noisy writes set the bits above each register's width, which must be dropped.
    task automatic apply_setting(input logic [POS_W-1:0] pos, input logic [1:0] mode,
                                 input logic aa, input logic ab, input logic ca,
                                 input logic cb, input logic noisy);
        logic [CFG_DATA_W-1:0] noise;
        noise = noisy ? CFG_DATA_W'($urandom) : '0;
        settle_quiet();
        write_reg(REG_POSITION, pos);
        write_reg(REG_CURVE_MODE, {noise[CFG_DATA_W-1:2], mode});
        write_reg(REG_AIR_A, {noise[CFG_DATA_W-1:1], aa});
        write_reg(REG_AIR_B, {noise[CFG_DATA_W-1:1], ab});
        write_reg(REG_CUE_A, {noise[CFG_DATA_W-1:1], ca});
        write_reg(REG_CUE_B, {noise[CFG_DATA_W-1:1], cb});
        settings_used = settings_used + 1;
    endtask

    initial begin : result_sink
        int hold;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (rx_hold_len > 0) begin
                i_stall = 1'b1;
                repeat (rx_hold_len) @(negedge i_clk);
                rx_hold_len = 0;
            end
            hold = pick_wait(rx_pace);
            if (hold > 0) begin
                i_stall = 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_stall = 1'b0;
            @(posedge i_clk);
            while (o_valid !== 1'b1) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        logic [POS_W-1:0] pos;
        int               burst;
        int               phase;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Settings straight out of reset.
        drive_request(16'sh7fff, 16'sh7fff);
        drive_request(16'sh8000, 16'sh8000);
        drive_request(16'shffff, 16'sh0001);

        apply_setting('0, MODE_LINEAR, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
        drive_request(16'sh7fff, 16'sh7fff);
        drive_request(16'sh8000, 16'sh8000);
        drive_request(16'sh0001, 16'shffff);

        apply_setting(POS_W'(FULL_POS), MODE_SQUARE, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
        drive_request(16'sh7fff, 16'sh8000);
        drive_request(16'sh8000, 16'sh7fff);

        // Beyond full B with the unused curve code.
        apply_setting(POS_TOP, MODE_SPARE, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
        drive_request(16'sh7fff, 16'sh7fff);
        drive_request(16'sh8000, 16'shffff);

        apply_setting(POS_W'(FULL_POS + 1), MODE_COSINE, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
        drive_request(16'sh8000, 16'sh8000);

        // Centre of the cosine curve: both decks near 0.707, so the master clips.
        apply_setting(POS_W'(FULL_POS / 2), MODE_COSINE, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
        drive_request(16'sh7fff, 16'sh7fff);
        drive_request(16'sh8000, 16'sh8000);
        drive_request(16'sh8000, 16'sh7fff);

        apply_setting(POS_W'(1234), MODE_SQUARE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        drive_request(16'sh3039, 16'sha460);

        // Deck A routed nowhere.
        apply_setting(POS_W'(FULL_POS / 2), MODE_LINEAR, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
        drive_request(16'sh7fff, 16'sh03e8);

        settle_quiet();
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, '1);
        drive_request(16'sh4e20, 16'shb1e0);

        phase = 0;
        while (requests_sent < RANDOM_REQUESTS + 17) begin
            case ($urandom_range(0, 5))
                0:       pos = '0;
                1:       pos = POS_W'(FULL_POS);
                2:       pos = POS_TOP;
                3:       pos = POS_W'($urandom_range(FULL_POS + 1, int'(POS_TOP)));
                default: pos = POS_W'($urandom_range(0, FULL_POS));
            endcase
            apply_setting(pos, 2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
                          1'($urandom), 1'($urandom), 1'b1);
            tx_pace = t_pace'($urandom_range(0, 2));
            rx_pace = t_pace'($urandom_range(0, 2));
            // Now and then the sink holds off while requests keep coming, to back up the pipe.
            if (phase == 3 || phase == 9) begin
                tx_pace     = PACE_STEADY;
                rx_hold_len = HOLD_CYCLES;
            end
            burst = $urandom_range(30, 70);
            repeat (burst) drive_request(pick_sample(), pick_sample());
            phase = phase + 1;
        end

        settle_quiet();
        repeat (8) @(posedge i_clk);
        $display("Summary: %0d requests over %0d register settings, %0d results compared.",
                 requests_sent, settings_used, mix_checked);
        $display("Summary: all curve codes, positions up to 8191 and every route combination.");
        if (mix_failures == 0) begin
            $display("two_deck_crossfade_mixer_tb: PASS");
        end else begin
            $display("two_deck_crossfade_mixer_tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/tdcm_pkg.sv
rtl/tdcm_lane.sv
rtl/tdcm_merge.sv
rtl/two_deck_crossfade_mixer.sv
tb/two_deck_crossfade_mixer_checker.sv
tb/two_deck_crossfade_mixer_tb.sv
